// ----- hw/rtl/twps_pkg.sv -----
// Shared types and constants for the tick-driven priority task scheduler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package twps_pkg;

    localparam int SLOT_W = 4;
    localparam int PRIO_W = 8;
    localparam int TICK_W = 32;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] priority_req;
        logic [TICK_W-1:0] wake_tick;
    } req_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0] chosen_slot;
        logic              chosen_idle;
        logic              switched;
        logic [TICK_W-1:0] tick_now;
    } rsp_word_t;

    typedef struct packed {
        logic create;
        logic park;
        logic wake;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/twps_cell.sv -----
// One task slot of the scheduler chain: slot state plus one stage of the selection wave.
// Depends on twps_pkg for the cell control struct and field widths.
`default_nettype none

module twps_cell #(
    parameter int PRIO_BITS = 8,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  twps_pkg::cell_ctrl_t          ctrl,
    input  wire                           sel,
    input  wire  [PRIO_BITS-1:0]          prio_in,
    input  wire  [twps_pkg::TICK_W-1:0]   wake_in,
    input  wire  [twps_pkg::TICK_W-1:0]   tick,
    input  wire                           cand_found_in,
    input  wire  [PRIO_BITS-1:0]          cand_prio_in,
    input  wire  [IDX_W-1:0]              cand_idx_in,
    output logic                          cand_found_out,
    output logic [PRIO_BITS-1:0]          cand_prio_out,
    output logic [IDX_W-1:0]              cand_idx_out
);
    import twps_pkg::*;

    logic                 used_reg, used_next;
    logic                 waiting_reg, waiting_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [TICK_W-1:0]    wake_reg, wake_next;
    logic                 found_reg, found_next;
    logic [PRIO_BITS-1:0] best_prio_reg, best_prio_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic                 eligible;
    logic                 take;

    always_comb
    begin
        used_next    = used_reg;
        waiting_next = waiting_reg;
        prio_next    = prio_reg;
        wake_next    = wake_reg;
        if (ctrl.create && sel)
        begin
            used_next    = 1'b1;
            prio_next    = prio_in;
            waiting_next = 1'b0;
        end
        else if (ctrl.park && sel)
        begin
            waiting_next = 1'b1;
            wake_next    = wake_in;
        end
        else if (ctrl.wake && used_reg && (prio_reg != '0) && waiting_reg &&
                 (wake_reg == tick))
        begin
            waiting_next = 1'b0;
        end
    end

    // pass the best candidate so far one cell on
    assign eligible = used_reg && !waiting_reg && (prio_reg != '0);
    assign take     = eligible && (!cand_found_in || (prio_reg > cand_prio_in));

    always_comb
    begin
        if (take)
        begin
            found_next     = 1'b1;
            best_prio_next = prio_reg;
            best_idx_next  = IDX_W'(CELL_IDX);
        end
        else
        begin
            found_next     = cand_found_in;
            best_prio_next = cand_prio_in;
            best_idx_next  = cand_idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            waiting_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            used_reg    <= used_next;
            waiting_reg <= waiting_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg      <= prio_next;
        wake_reg      <= wake_next;
        best_prio_reg <= best_prio_next;
        best_idx_reg  <= best_idx_next;
    end

    assign cand_found_out = found_reg;
    assign cand_prio_out  = best_prio_reg;
    assign cand_idx_out   = best_idx_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tick_wake_priority_task_scheduler_unit.sv -----
// Top level of the tick-driven priority task scheduler: control sequencer and cell chain.
// Depends on twps_pkg and twps_cell.
//
// Fixed-priority scheduler over MAX_TASKS task slots, one slot per cell of a chain.
// Create and wait words update the addressed slot and answer in the cycle after
// acceptance with the current selection and switched low. A tick word first advances
// the tick counter; then every waiting slot compares its wake tick against the counter,
// the selection wave walks the chain one cell per cycle, and the choice is registered.
// The highest nonzero priority wins, the lowest slot on a tie; with no ready slot the
// idle task is chosen. One word is in flight at a time. There is no clearing pass
// after reset.
`default_nettype none

module tick_wake_priority_task_scheduler_unit #(
    parameter int MAX_TASKS = 16,
    parameter int PRIO_BITS = 8
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  twps_pkg::req_word_t req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output twps_pkg::rsp_word_t rsp
);
    import twps_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAKE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [IDX_W-1:0]  run_slot_reg, run_slot_next;
    logic              run_idle_reg, run_idle_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_word_t         rsp_reg, rsp_next;

    logic                 accept;
    cell_ctrl_t           ctrl;
    logic [PRIO_BITS-1:0] prio_in;
    logic [MAX_TASKS-1:0] wr_sel;
    logic                 found_c [0:MAX_TASKS];
    logic [PRIO_BITS-1:0] prio_c  [0:MAX_TASKS];
    logic [IDX_W-1:0]     idx_c   [0:MAX_TASKS];
    logic                 best_found;
    logic [IDX_W-1:0]     best_idx;
    logic                 changed;

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;

    assign ctrl.create = accept && (req.command == CMD_CREATE);
    assign ctrl.park   = accept && (req.command == CMD_WAIT);
    assign ctrl.wake   = (state_reg == S_WAKE);
    assign prio_in     = PRIO_BITS'(req.priority_req);

    assign found_c[0] = 1'b0;
    assign prio_c[0]  = '0;
    assign idx_c[0]   = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++)
        begin : g_cell
            assign wr_sel[g] = (32'(req.slot) == 32'(g));

            twps_cell #(
                .PRIO_BITS (PRIO_BITS),
                .IDX_W     (IDX_W),
                .CELL_IDX  (g)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (ctrl),
                .sel            (wr_sel[g]),
                .prio_in        (prio_in),
                .wake_in        (req.wake_tick),
                .tick           (tick_reg),
                .cand_found_in  (found_c[g]),
                .cand_prio_in   (prio_c[g]),
                .cand_idx_in    (idx_c[g]),
                .cand_found_out (found_c[g+1]),
                .cand_prio_out  (prio_c[g+1]),
                .cand_idx_out   (idx_c[g+1])
            );
        end
    endgenerate

    assign best_found = found_c[MAX_TASKS] && (prio_c[MAX_TASKS] != '0);
    assign best_idx   = idx_c[MAX_TASKS];
    assign changed    = best_found ? (run_idle_reg || (run_slot_reg != best_idx))
                                   : !run_idle_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tick_next      = tick_reg;
        run_slot_next  = run_slot_reg;
        run_idle_next  = run_idle_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == CMD_TICK)
                    begin
                        tick_next  = tick_reg + 32'd1;
                        state_next = S_WAKE;
                    end
                    else
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.chosen_slot = SLOT_W'(run_slot_reg);
                        rsp_next.chosen_idle = run_idle_reg;
                        rsp_next.switched    = 1'b0;
                        rsp_next.tick_now    = tick_reg;
                    end
                end
            end
            S_WAKE:
            begin
                cnt_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cnt_reg == IDX_W'(MAX_TASKS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                run_idle_next        = !best_found;
                run_slot_next        = best_found ? best_idx : '0;
                rsp_valid_next       = 1'b1;
                rsp_next.chosen_slot = best_found ? SLOT_W'(best_idx) : '0;
                rsp_next.chosen_idle = !best_found;
                rsp_next.switched    = changed;
                rsp_next.tick_now    = tick_reg;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            run_slot_reg  <= '0;
            run_idle_reg  <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tick_reg      <= tick_next;
            run_slot_reg  <= run_slot_next;
            run_idle_reg  <= run_idle_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/twps_checker.sv -----
// Port-level checks for the tick-driven priority task scheduler, bound to its top level.
// Depends on twps_pkg and tick_wake_priority_task_scheduler_unit.
`default_nettype none

module twps_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 req_valid,
    input wire                 req_stall,
    input twps_pkg::req_word_t req,
    input wire                 rsp_valid,
    input wire                 rsp_stall,
    input twps_pkg::rsp_word_t rsp
);
    import twps_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response word changed");

    a_no_take_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("request taken while response blocked");

    a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.chosen_idle |-> rsp.chosen_slot == '0)
        else $error("idle selection reports a nonzero slot");

    a_table_op_answer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.command != CMD_TICK)
        |=> rsp_valid && !rsp.switched)
        else $error("create or wait did not answer at once without a switch");

endmodule

bind tick_wake_priority_task_scheduler_unit twps_checker u_twps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
